// ===== sv/mac_address_set_table_core_macros.svh =====
// ---------------------------------------------------------------------------
// MAC address set table: assertion macros
// Shared property forms for the checker of the table core.
// ---------------------------------------------------------------------------
`ifndef MAC_ADDRESS_SET_TABLE_CORE_MACROS_SVH
`define MAC_ADDRESS_SET_TABLE_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define MAST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define MAST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/mast_pkg.sv =====
// ---------------------------------------------------------------------------
// MAC address set table: package
// Request and status codes, beat widths and controller interface types.
// ---------------------------------------------------------------------------
package mast_pkg;

   localparam int MAC_W       = 48;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int RSP_DATA_W  = 8;

   // Request kinds carried on the request tuser.
   typedef enum logic [REQ_W-1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_PRESENT   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } rsp_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_EXEC,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // take the request beat, clear index and hit
      logic rd_idx;      // read the entry at the scan index
      logic rd_next;     // read the entry after the scan index
      logic set_hit;     // record a match at the scan index
      logic inc_idx;     // advance the scan index
      logic idx_to_pos;  // load the scan index with the match position
      logic exec;        // latch the result status
      logic append;      // write the address at the end, count up
      logic shift_wr;    // move the read entry down into the scan index
      logic dec_count;   // count down after a removal
      logic clear_count; // empty the table
      logic load_rsp;    // load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      req_kind_type req_kind;
      logic         idx_lt_count;
      logic         next_lt_count;
      logic         match;
      logic         hit;
      logic         full;
      logic         rsp_busy;
   } ctrl_stat_type;

endpackage

// ===== sv/mast_ctrl.sv =====
// ---------------------------------------------------------------------------
// MAC address set table: controller
// Sequences the search, the table update and the compaction of one request.
// ---------------------------------------------------------------------------
module mast_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  mast_pkg::ctrl_stat_type stat,
   output mast_pkg::ctrl_cmd_type  cmd
);
   import mast_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (stat.idx_lt_count) begin
               cmd.rd_idx = 1'b1;
               state_in   = S_COMPARE;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_COMPARE: begin
            if (stat.match) begin
               cmd.set_hit = 1'b1;
               state_in    = S_EXEC;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_FINISH;
            case (stat.req_kind)
               REQ_ADD: begin
                  cmd.append = !stat.hit && !stat.full;
               end
               REQ_REMOVE: begin
                  if (stat.hit) begin
                     cmd.idx_to_pos = 1'b1;
                     state_in       = S_SHIFT_RD;
                  end
               end
               REQ_CLEAR: begin
                  cmd.clear_count = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (stat.next_lt_count) begin
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end else begin
               cmd.dec_count = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/mast_datapath.sv =====
// ---------------------------------------------------------------------------
// MAC address set table: datapath
// Address memory, count, scan index, match flag and result register.
// ---------------------------------------------------------------------------
module mast_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mast_pkg::REQ_W-1:0]        req_tuser,
   input  logic [mast_pkg::MAC_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mast_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  mast_pkg::ctrl_cmd_type            cmd,
   output mast_pkg::ctrl_stat_type           stat
);
   import mast_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [MAC_W-1:0]      mem [TABLE_DEPTH];
   logic [MAC_W-1:0]      rd_data_ff;
   logic [MAC_W-1:0]      mac_ff;
   req_kind_type          req_kind_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      idx_in;
   logic [CNT_W-1:0]      idx_next;
   logic [CNT_W-1:0]      pos_ff;
   logic                  hit_ff;
   rsp_status_type        status_ff;
   rsp_status_type        status_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [31:0]           count_wide;
   logic                  full;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic [MAC_W-1:0]      wr_data;
   logic                  wr_en;
   logic                  rd_en;

   assign idx_next = idx_ff + CNT_W'(1);
   assign full     = (count_ff == CNT_W'(TABLE_DEPTH));

   // Memory port selection: one read and one write per cycle.
   assign rd_en   = cmd.rd_idx || cmd.rd_next;
   assign rd_addr = cmd.rd_next ? idx_next[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_en   = cmd.append || cmd.shift_wr;
   assign wr_addr = cmd.append ? count_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.append ? mac_ff : rd_data_ff;

   // Address memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Request capture and match bookkeeping.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mac_ff      <= req_tdata;
         req_kind_ff <= req_kind_type'(req_tuser);
      end
      if (cmd.capture) begin
         hit_ff <= 1'b0;
      end else if (cmd.set_hit) begin
         hit_ff <= 1'b1;
         pos_ff <= idx_ff;
      end
      idx_ff <= idx_in;
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // Scan index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (cmd.idx_to_pos) begin
         idx_in = pos_ff;
      end else if (cmd.inc_idx) begin
         idx_in = idx_next;
      end
   end

   // Result status, decided before the table changes.
   always_comb begin
      case (req_kind_ff)
         REQ_LOOKUP: status_in = hit_ff ? ST_DONE : ST_NOT_FOUND;
         REQ_ADD: begin
            if (hit_ff) begin
               status_in = ST_PRESENT;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_DONE;
            end
         end
         REQ_REMOVE: status_in = hit_ff ? ST_DONE : ST_NOT_FOUND;
         default:    status_in = ST_DONE;
      endcase
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register: holds a finished beat while the next request runs.
   assign count_wide  = 32'(count_ff);
   assign rsp_data_in = {count_wide[COUNT_OUT_W-1:0], status_ff, hit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status toward the controller.
   assign stat.req_kind      = req_kind_ff;
   assign stat.idx_lt_count  = (idx_ff < count_ff);
   assign stat.next_lt_count = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) < {1'b0, count_ff};
   assign stat.match         = (rd_data_ff == mac_ff);
   assign stat.hit           = hit_ff;
   assign stat.full          = full;
   assign stat.rsp_busy      = rsp_valid_ff && !rsp_tready;

endmodule

// ===== sv/mac_address_set_table_core.sv =====
// ---------------------------------------------------------------------------
// MAC address set table core
// Ordered set of distinct 48-bit MAC addresses with lookup, add, remove
// and clear requests.
// ---------------------------------------------------------------------------
// One request beat at a time gives one result beat. The table sits in a
// memory of TABLE_DEPTH entries with registered read data, and every step of
// the linear search and of the compaction after a removal reads an entry,
// then uses the registered data. The search stops at the first hit. A removal
// moves each later entry down one place and then updates the count. The next
// request can be taken in the cycle after the result is loaded. A finished
// result waits in an output register, so the next request is taken while it
// is still unread; that request then holds its own result until the register
// is read. An add of a new address to a full table is dropped with status
// full; entry_count carries the low five bits of the count.
module mac_address_set_table_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mast_pkg::MAC_W-1:0]      req_tdata,  // [47:0] mac_addr
   input  logic [mast_pkg::REQ_W-1:0]      req_tuser,  // [1:0] req_type
   // Result channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mast_pkg::RSP_DATA_W-1:0] rsp_tdata   // [0] found, [2:1] status,
                                                       // [7:3] entry_count
);
   import mast_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequencer.
   mast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Table storage and result path.
   mast_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== sv/mast_checker.sv =====
// ---------------------------------------------------------------------------
// MAC address set table: port checker
// Watches the result beats of the table core and is bound to it below.
// ---------------------------------------------------------------------------
`include "mac_address_set_table_core_macros.svh"

module mast_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mast_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mast_pkg::*;

   localparam int COUNT_MAX = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;

   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [31:0]         rsp_count;
   logic                rsp_absent;
   logic                rsp_full;

   assign rsp_found  = rsp_tdata[0];
   assign rsp_status = rsp_tdata[2:1];
   assign rsp_count  = 32'(rsp_tdata[7:3]);
   assign rsp_absent = (rsp_status == ST_NOT_FOUND) || (rsp_status == ST_FULL);
   assign rsp_full   = rsp_tvalid && (rsp_status == ST_FULL);

   // A stalled result beat stays put.
   `MAST_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The count never exceeds the table capacity.
   `MAST_ASSERT_IMPL(a_count_cap, rsp_tvalid, rsp_count <= 32'(COUNT_MAX))

   // An add that found its address must have seen it in the table.
   `MAST_ASSERT_IMPL(a_present_found, rsp_tvalid && (rsp_status == ST_PRESENT), rsp_found)

   // Not found and table full only happen for absent addresses.
   `MAST_ASSERT_IMPL(a_absent_flag, rsp_tvalid && rsp_absent, !rsp_found)

   // A full report means the table held every entry it can.
   `MAST_ASSERT_IMPL(a_full_count, rsp_full && (TABLE_DEPTH < 32), rsp_count == 32'(TABLE_DEPTH))

endmodule

bind mac_address_set_table_core mast_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_mast_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/mac_table_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// MAC address set table: response tracker
// Mirror of the address table and queue of expected response beats, used by
// the testbench to predict and check every result of the table core.
// ---------------------------------------------------------------------------
package mac_table_tb_pkg;

   import mast_pkg::*;

   // Fields of one response beat, as the mirror predicts them.
   typedef struct packed {
      logic                   found;
      rsp_status_type         status;
      logic [COUNT_OUT_W-1:0] entry_count;
   } table_response_type;

   class mac_table_scoreboard;

      int unsigned        table_depth;
      logic [MAC_W-1:0]   stored_macs[$];
      table_response_type expected_responses[$];
      int unsigned        error_count;

      function new(int unsigned depth);
         table_depth = depth;
         error_count = 0;
      endfunction

      function int unsigned outstanding();
         return expected_responses.size();
      endfunction

      // One line per mismatch; the count decides the verdict at the end.
      task report_mismatch(string what, logic [RSP_DATA_W-1:0] got,
                           logic [RSP_DATA_W-1:0] want);
         $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
         error_count++;
      endtask

      // Apply one accepted request beat to the mirror and queue its response.
      function void note_request(req_kind_type kind, logic [MAC_W-1:0] mac);
         int                 pos;
         table_response_type rsp;
         pos = -1;
         for (int i = 0; i < stored_macs.size(); i++) begin
            if (stored_macs[i] == mac) begin
               pos = i;
               break;
            end
         end
         rsp.found = (pos >= 0);
         case (kind)
            REQ_LOOKUP: begin
               rsp.status = (pos >= 0) ? ST_DONE : ST_NOT_FOUND;
            end
            REQ_ADD: begin
               if (pos >= 0) begin
                  rsp.status = ST_PRESENT;
               end else if (stored_macs.size() >= table_depth) begin
                  rsp.status = ST_FULL;
               end else begin
                  stored_macs.insert(stored_macs.size(), mac);
                  rsp.status = ST_DONE;
               end
            end
            REQ_REMOVE: begin
               // Deleting from the queue keeps the later entries in order.
               if (pos >= 0) begin
                  stored_macs.delete(pos);
                  rsp.status = ST_DONE;
               end else begin
                  rsp.status = ST_NOT_FOUND;
               end
            end
            default: begin
               stored_macs.delete();
               rsp.status = ST_DONE;
            end
         endcase
         rsp.entry_count = COUNT_OUT_W'(stored_macs.size());
         expected_responses.insert(expected_responses.size(), rsp);
      endfunction

      // Compare one accepted response beat with the oldest expectation.
      task check_response(logic [RSP_DATA_W-1:0] beat);
         table_response_type want;
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response beat", beat, '0);
            return;
         end
         want = expected_responses.pop_front();
         if (beat[0] !== want.found)
            report_mismatch("found", RSP_DATA_W'(beat[0]), RSP_DATA_W'(want.found));
         if (beat[2:1] !== want.status)
            report_mismatch("status", RSP_DATA_W'(beat[2:1]), RSP_DATA_W'(want.status));
         if (beat[7:3] !== want.entry_count)
            report_mismatch("entry_count", RSP_DATA_W'(beat[7:3]),
                            RSP_DATA_W'(want.entry_count));
      endtask

   endclass

endpackage

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// MAC address set table core testbench
// Drives lookup, add, remove and clear beats into the table core, mirrors the
// table in a tracker and checks every response beat field by field. A short
// directed part fills, overflows and empties the table; the random part works
// on a small address pool so that hits, duplicates, full drops and removals
// happen often, with bursty requests and a stalling response side.
// ---------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import mast_pkg::*;
   import mac_table_tb_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 1125;
   localparam int POOL_SIZE     = 24;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 10;
   localparam int CYCLE_LIMIT   = 400000;

   // Ways the response side paces its ready.
   typedef enum int {
      SINK_OPEN,
      SINK_PATTERN,
      SINK_RANDOM,
      SINK_SLOW
   } sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [MAC_W-1:0]      req_tdata = '0;
   req_kind_type          req_tuser = REQ_LOOKUP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bit                    hold_request = 1'b0;
   logic [MAC_W-1:0]      addr_pool [POOL_SIZE];
   mac_table_scoreboard   tracker = new(TABLE_DEPTH);

   mac_address_set_table_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [47:0] mac_addr
      .req_tuser  (req_tuser),   // [1:0] req_type
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] found, [2:1] status, [7:3] entry_count
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every response beat as it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(rsp_tdata);
   end

   // Hard stop if the run hangs.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   function automatic logic [MAC_W-1:0] random_mac();
      logic [63:0] word;
      word = {$urandom, $urandom};
      return word[MAC_W-1:0];
   endfunction

   // Replace one pool address, sometimes by a one-bit neighbor of another.
   task automatic refresh_pool_entry();
      int slot;
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 2) == 0)
         addr_pool[slot] = addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                           ^ (48'd1 << $urandom_range(0, MAC_W - 1));
      else
         addr_pool[slot] = random_mac();
   endtask

   // Offer one request beat from a falling edge until it is taken.
   task automatic send_request(req_kind_type kind, logic [MAC_W-1:0] mac);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= mac;
      do
         @(posedge clock);
      while (!req_tready);
      tracker.note_request(kind, mac);
      @(negedge clock);
   endtask

   // Drop valid for a gap, or until every response has come back.
   task automatic pause_sender(int gap, bit until_drained);
      req_tvalid <= 1'b0;
      if (until_drained) begin
         do
            @(negedge clock);
         while (tracker.outstanding() != 0);
      end else begin
         repeat (gap) @(negedge clock);
      end
   endtask

   // Mostly pool addresses, so the table sees hits and fills up.
   task automatic pick_request(output req_kind_type kind, output logic [MAC_W-1:0] mac,
                               input int add_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         kind = REQ_CLEAR;
      else if (roll < 27)
         kind = REQ_LOOKUP;
      else if (roll < 27 + add_pct)
         kind = REQ_ADD;
      else
         kind = REQ_REMOVE;
      if ($urandom_range(0, 9) == 0)
         mac = random_mac();
      else
         mac = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
   endtask

   // Response side: runs of different ready patterns, and a long hold-off
   // when the request side asks for one.
   initial begin : response_sink
      int            span;
      int            slow;
      logic [7:0]    pattern;
      sink_mode_type mode;
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            mode    = sink_mode_type'($urandom_range(0, 3));
            span    = $urandom_range(8, 64);
            pattern = 8'($urandom);
            slow    = $urandom_range(2, 8);
            for (int k = 0; k < span; k++) begin
               case (mode)
                  SINK_OPEN:    rsp_tready <= 1'b1;
                  SINK_PATTERN: rsp_tready <= pattern[k % 8];
                  SINK_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
                  default:      rsp_tready <= (k % slow == 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // Request side: reset, directed beats, random bursts, then drain.
   initial begin : request_source
      req_kind_type     kind;
      logic [MAC_W-1:0] mac;
      logic [MAC_W-1:0] mid_mac;
      logic [MAC_W-1:0] last_mac;
      int               sent;
      int               burst;
      int               add_pct;

      foreach (addr_pool[i]) addr_pool[i] = random_mac();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: miss, remove of an absent address, clear.
      send_request(REQ_LOOKUP, '0);
      send_request(REQ_REMOVE, '1);
      send_request(REQ_CLEAR, '1);
      // Extreme addresses, a duplicate add and a hit.
      send_request(REQ_ADD, '0);
      send_request(REQ_ADD, '1);
      send_request(REQ_ADD, '0);
      send_request(REQ_LOOKUP, '1);
      // Fill the table; the low byte keeps these distinct.
      for (int i = 1; i <= TABLE_DEPTH - 2; i++) begin
         mac = random_mac();
         mac[7:0] = 8'(i);
         if (i == TABLE_DEPTH / 2)
            mid_mac = mac;
         last_mac = mac;
         send_request(REQ_ADD, mac);
      end
      // Full table: a new address is dropped, a stored one reports present.
      mac = random_mac();
      mac[7:0] = 8'hA5;
      send_request(REQ_ADD, mac);
      send_request(REQ_ADD, '1);
      // Remove the first, the last and a middle entry, then check the gap.
      send_request(REQ_REMOVE, '0);
      send_request(REQ_REMOVE, last_mac);
      send_request(REQ_REMOVE, mid_mac);
      send_request(REQ_LOOKUP, mid_mac);
      // Clearing a non-empty table still reports the hit.
      send_request(REQ_CLEAR, '1);

      // Random bursts with changing add/remove balance.
      sent    = 0;
      add_pct = 40;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            if (sent % 150 == 0)
               add_pct = $urandom_range(20, 55);
            if (sent % 64 == 0)
               refresh_pool_entry();
            pick_request(kind, mac, add_pct);
            send_request(kind, mac);
            sent++;
            // Long response stall while requests keep coming.
            if (sent % 300 == 100)
               hold_request = 1'b1;
            // Let the core run dry once in a while.
            if (sent % 300 == 250)
               pause_sender(1, 1'b1);
         end
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 12), 1'b0);
      end

      pause_sender(1, 1'b1);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (tracker.error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
